@@ rtl/erm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Euler rotation matrix package
// Shared constants, types and fixed-point helpers for the rotation pipeline.
// ----------------------------------------------------------------------------
package erm_pkg;

  // Fraction bits of the internal sine, cosine and product format.
  localparam int unsigned QB = 30;

  // Register stages inside one sine/cosine unit.
  localparam int unsigned TRIG_LAT = 33;

  // Register stages after the sine/cosine units (products, sums, output).
  localparam int unsigned PROD_LAT = 3;

  // Number of series steps for sine and cosine.
  localparam int unsigned SERIES_TERMS = 9;

  // round(pi/180 * 2^42)
  localparam logic [36:0] RAD_PER_DEG = 37'd76760392275;

  // 1.0 in Q30, and half an LSB of a Q30 product.
  localparam logic [30:0] QONE  = 31'h4000_0000;
  localparam logic [61:0] QHALF = 62'h2000_0000;

  // Side data that travels along the series pipeline.
  typedef struct packed {
    logic [29:0] rad;
    logic [29:0] x2;
    logic [1:0]  quad;
    logic        swap;
  } trig_side_t;

  // Signed Q30 product, magnitude rounded half up, i.e. half away from zero.
  function automatic logic signed [31:0] smulq(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    logic        neg;
    logic [30:0] ma;
    logic [30:0] mb;
    logic [61:0] p;
    logic [30:0] m;
    neg = a[31] ^ b[31];
    ma  = a[31] ? 31'(-a) : 31'(a);
    mb  = b[31] ? 31'(-b) : 31'(b);
    p   = ma * mb;
    m   = 31'((p + QHALF) >> QB);
    return neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
  endfunction

endpackage

@@ rtl/erm_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Euler rotation matrix channels
// Valid/ready channels for the angle triple and the nine matrix entries.
// ----------------------------------------------------------------------------
interface erm_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] angle_x;
  logic signed [15:0] angle_y;
  logic signed [15:0] angle_z;

  modport source (output valid, angle_x, angle_y, angle_z, input ready);
  modport sink   (input valid, angle_x, angle_y, angle_z, output ready);
endinterface

interface erm_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] m00;
  logic signed [15:0] m01;
  logic signed [15:0] m02;
  logic signed [15:0] m10;
  logic signed [15:0] m11;
  logic signed [15:0] m12;
  logic signed [15:0] m20;
  logic signed [15:0] m21;
  logic signed [15:0] m22;

  modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  input ready);
  modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  output ready);
endinterface

@@ rtl/erm_trig.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Euler rotation matrix sine/cosine unit
// Pipelined angle reduction, octant fold and Taylor series, Q30 results.
// ----------------------------------------------------------------------------
module erm_trig #(
  parameter int unsigned ANGLE_FRACTION_BITS = 6
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [15:0] angle_i,
  output logic signed [31:0] sin_o,
  output logic signed [31:0] cos_o
);

  localparam int unsigned A      = ANGLE_FRACTION_BITS;
  localparam int unsigned FULL   = 360 << A;
  localparam int unsigned QTR    = 90 << A;
  localparam int unsigned EIGHTH = 45 << A;
  localparam int unsigned NWRAP  = (32768 + FULL - 1) / FULL;
  localparam int unsigned OFFSET = NWRAP * FULL;
  localparam int unsigned UW     = $clog2(32768 + OFFSET);
  localparam int unsigned RW     = $clog2(FULL) + 1;
  localparam int unsigned TW     = $clog2(EIGHTH + 1);
  localparam int unsigned PW     = TW + 37;
  localparam int unsigned RSH    = 12 + A;
  localparam logic [UW-1:0] M1   = UW'((64'd1 << UW) / FULL);
  localparam logic [PW-1:0] RRND = PW'(64'd1 << (11 + A));
  localparam int unsigned NS     = 3 * erm_pkg::SERIES_TERMS;

  // Stage 1: shift the angle positive and multiply by the reciprocal of a full turn.
  logic [UW-1:0]   s1_u_q;
  logic [2*UW-1:0] s1_p_q;
  logic [UW-1:0]   u_d;

  always_comb begin
    int sum;
    sum = int'(angle_i) + int'(OFFSET);
    u_d = UW'(sum);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_u_q <= u_d;
      s1_p_q <= u_d * M1;
    end
  end

  // Stage 2: remainder modulo a full turn, with one correction step.
  logic [RW-1:0] s2_r_q;
  logic [RW-1:0] r_d;

  always_comb begin
    logic [UW-1:0] q0;
    logic [UW-1:0] rem;
    q0  = s1_p_q[2*UW-1:UW];
    rem = s1_u_q - UW'(q0 * FULL);
    if (rem >= UW'(FULL)) begin
      rem = rem - UW'(FULL);
    end
    r_d = RW'(rem);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_r_q <= r_d;
    end
  end

  // Stage 3: quadrant and fold into the first octant.
  logic [TW-1:0] s3_t_q;
  logic [1:0]    s3_quad_q;
  logic          s3_swap_q;
  logic [TW-1:0] t_d;
  logic [1:0]    quad_d;
  logic          swap_d;

  always_comb begin
    logic [RW-1:0] t;
    if (s2_r_q >= RW'(3 * QTR)) begin
      quad_d = 2'd3;
      t      = s2_r_q - RW'(3 * QTR);
    end else if (s2_r_q >= RW'(2 * QTR)) begin
      quad_d = 2'd2;
      t      = s2_r_q - RW'(2 * QTR);
    end else if (s2_r_q >= RW'(QTR)) begin
      quad_d = 2'd1;
      t      = s2_r_q - RW'(QTR);
    end else begin
      quad_d = 2'd0;
      t      = s2_r_q;
    end
    swap_d = (t > RW'(EIGHTH));
    t_d    = swap_d ? TW'(RW'(QTR) - t) : TW'(t);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s3_t_q    <= t_d;
      s3_quad_q <= quad_d;
      s3_swap_q <= swap_d;
    end
  end

  // Stage 4: degrees to radians product, formed at the full product width.
  logic [PW-1:0] s4_prod_q;
  logic [1:0]    s4_quad_q;
  logic          s4_swap_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s4_prod_q <= s3_t_q * erm_pkg::RAD_PER_DEG + RRND;
      s4_quad_q <= s3_quad_q;
      s4_swap_q <= s3_swap_q;
    end
  end

  // Stage 5: radians and their square.
  erm_pkg::trig_side_t side_q [0:NS];
  erm_pkg::trig_side_t side_d;

  always_comb begin
    logic [29:0] rad;
    logic [59:0] sq;
    rad         = 30'(s4_prod_q >> RSH);
    sq          = rad * rad;
    side_d.rad  = rad;
    side_d.x2   = 30'((sq + 60'(erm_pkg::QHALF)) >> erm_pkg::QB);
    side_d.quad = s4_quad_q;
    side_d.swap = s4_swap_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_d;
    end
  end

  // Side data follows the series stages.
  for (genvar n = 1; n <= NS; n++) begin : g_side
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[n] <= side_q[n-1];
      end
    end
  end

  // Series steps: each takes three stages (product, reciprocal, correction).
  logic [29:0] ys_q  [0:erm_pkg::SERIES_TERMS-1];
  logic [29:0] yc_q  [0:erm_pkg::SERIES_TERMS-1];
  logic [29:0] ysb_q [0:erm_pkg::SERIES_TERMS-1];
  logic [29:0] ycb_q [0:erm_pkg::SERIES_TERMS-1];
  logic [61:0] ps_q  [0:erm_pkg::SERIES_TERMS-1];
  logic [61:0] pc_q  [0:erm_pkg::SERIES_TERMS-1];
  logic [30:0] ts_q  [0:erm_pkg::SERIES_TERMS-1];
  logic [30:0] tc_q  [0:erm_pkg::SERIES_TERMS-1];
  logic [30:0] tsi   [0:erm_pkg::SERIES_TERMS-1];
  logic [30:0] tci   [0:erm_pkg::SERIES_TERMS-1];

  for (genvar j = 0; j < erm_pkg::SERIES_TERMS; j++) begin : g_step
    localparam int unsigned K      = erm_pkg::SERIES_TERMS - j;
    localparam int unsigned DS     = (2 * K) * (2 * K + 1);
    localparam int unsigned DC     = (2 * K - 1) * (2 * K);
    localparam logic [31:0] MS     = 32'((64'd1 << 32) / DS);
    localparam logic [31:0] MC     = 32'((64'd1 << 32) / DC);

    // The first step starts from a term of one.
    if (j == 0) begin : g_first
      assign tsi[j] = erm_pkg::QONE;
      assign tci[j] = erm_pkg::QONE;
    end else begin : g_next
      assign tsi[j] = ts_q[j-1];
      assign tci[j] = tc_q[j-1];
    end

    logic [60:0] prs;
    logic [60:0] prc;
    logic [30:0] tsn;
    logic [30:0] tcn;

    assign prs = side_q[3*j].x2 * tsi[j];
    assign prc = side_q[3*j].x2 * tci[j];

    // Quotient estimate is low by at most one.
    always_comb begin
      logic [29:0] qs;
      logic [29:0] qc;
      logic [29:0] rs;
      logic [29:0] rc;
      qs  = ps_q[j][61:32];
      qc  = pc_q[j][61:32];
      rs  = ysb_q[j] - 30'(qs * DS);
      rc  = ycb_q[j] - 30'(qc * DC);
      if (rs >= 30'(DS)) begin
        qs = qs + 30'd1;
      end
      if (rc >= 30'(DC)) begin
        qc = qc + 30'd1;
      end
      tsn = erm_pkg::QONE - 31'(qs);
      tcn = erm_pkg::QONE - 31'(qc);
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ys_q[j]  <= 30'((prs + 61'(erm_pkg::QHALF)) >> erm_pkg::QB);
        yc_q[j]  <= 30'((prc + 61'(erm_pkg::QHALF)) >> erm_pkg::QB);
        ysb_q[j] <= ys_q[j];
        ycb_q[j] <= yc_q[j];
        ps_q[j]  <= ys_q[j] * MS;
        pc_q[j]  <= yc_q[j] * MC;
        ts_q[j]  <= tsn;
        tc_q[j]  <= tcn;
      end
    end
  end

  // Final stage: sine from the series, octant swap and quadrant signs.
  logic signed [31:0] sin_d;
  logic signed [31:0] cos_d;

  always_comb begin
    logic [60:0]        pr;
    logic [30:0]        s_m;
    logic [30:0]        c_m;
    logic signed [31:0] s;
    logic signed [31:0] c;
    pr  = side_q[NS].rad * ts_q[erm_pkg::SERIES_TERMS-1];
    s_m = 31'((pr + 61'(erm_pkg::QHALF)) >> erm_pkg::QB);
    c_m = tc_q[erm_pkg::SERIES_TERMS-1];
    if (side_q[NS].swap) begin
      s = $signed({1'b0, c_m});
      c = $signed({1'b0, s_m});
    end else begin
      s = $signed({1'b0, s_m});
      c = $signed({1'b0, c_m});
    end
    case (side_q[NS].quad)
      2'd0: begin
        sin_d = s;
        cos_d = c;
      end
      2'd1: begin
        sin_d = c;
        cos_d = -s;
      end
      2'd2: begin
        sin_d = -s;
        cos_d = -c;
      end
      default: begin
        sin_d = -c;
        cos_d = s;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sin_o <= sin_d;
      cos_o <= cos_d;
    end
  end

endmodule

@@ rtl/euler_rotation_matrix.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Euler rotation matrix
// Nine entries of Rz*Ry*Rx from three fixed-point angles, Q1.14 saturated.
// ----------------------------------------------------------------------------
// Datapath: an accepted item passes through the sine and cosine units, then
//   cross products, triple products and output rounding, each registered.
// Throughput: one item per cycle; the whole pipeline holds while the output
//   register is full and not taken.
// Reset clears only the valid bits of the pipeline; payload is not reset.
module euler_rotation_matrix #(
  parameter int unsigned OUT_FRACTION_BITS   = 14,
  parameter int unsigned ANGLE_FRACTION_BITS = 6
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  erm_in_if.sink   angle_i,
  erm_out_if.source matrix_o
);

  localparam int unsigned LAT = erm_pkg::TRIG_LAT + erm_pkg::PROD_LAT;
  localparam int unsigned SH  = erm_pkg::QB - OUT_FRACTION_BITS;
  localparam logic [32:0] LIM = 33'(64'd1 << OUT_FRACTION_BITS);
  localparam logic [32:0] RND = (SH > 0) ? 33'(64'd1 << (SH - 1)) : 33'd0;

  // Round half away from zero to the output format and saturate to +-1.0.
  function automatic logic [15:0] to_out(input logic signed [32:0] v);
    logic        neg;
    logic [32:0] m;
    logic [32:0] r;
    neg = v[32];
    m   = neg ? 33'(-v) : 33'(v);
    m   = (m + RND) >> SH;
    if (m > LIM) begin
      m = LIM;
    end
    r = neg ? -m : m;
    return r[15:0];
  endfunction

  // The pipeline advances unless a result waits at the output.
  logic en;
  logic [LAT-1:0] vld_q;

  assign en            = !vld_q[LAT-1] || matrix_o.ready;
  assign angle_i.ready = en;
  assign matrix_o.valid = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], angle_i.valid};
    end
  end

  // Sine and cosine of each angle.
  logic signed [31:0] sx;
  logic signed [31:0] cx;
  logic signed [31:0] sy;
  logic signed [31:0] cy;
  logic signed [31:0] sz;
  logic signed [31:0] cz;

  erm_trig #(.ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS)) u_trig_x (
    .clk_i   (clk_i),
    .en_i    (en),
    .angle_i (angle_i.angle_x),
    .sin_o   (sx),
    .cos_o   (cx)
  );

  erm_trig #(.ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS)) u_trig_y (
    .clk_i   (clk_i),
    .en_i    (en),
    .angle_i (angle_i.angle_y),
    .sin_o   (sy),
    .cos_o   (cy)
  );

  erm_trig #(.ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS)) u_trig_z (
    .clk_i   (clk_i),
    .en_i    (en),
    .angle_i (angle_i.angle_z),
    .sin_o   (sz),
    .cos_o   (cz)
  );

  // First products: sin x sin y and cos x sin y; the rest pass along.
  logic signed [31:0] sxsy_q;
  logic signed [31:0] cxsy_q;
  logic signed [31:0] sx_q;
  logic signed [31:0] cx_q;
  logic signed [31:0] sy_q;
  logic signed [31:0] cy_q;
  logic signed [31:0] sz_q;
  logic signed [31:0] cz_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sxsy_q <= erm_pkg::smulq(sx, sy);
      cxsy_q <= erm_pkg::smulq(cx, sy);
      sx_q   <= sx;
      cx_q   <= cx;
      sy_q   <= sy;
      cy_q   <= cy;
      sz_q   <= sz;
      cz_q   <= cz;
    end
  end

  // Second products for the matrix terms; sin y passes along unmultiplied.
  logic signed [31:0] p_sxsy_cz_q;
  logic signed [31:0] p_cx_sz_q;
  logic signed [31:0] p_cxsy_cz_q;
  logic signed [31:0] p_sx_sz_q;
  logic signed [31:0] p_cy_cz_q;
  logic signed [31:0] p_cy_sz_q;
  logic signed [31:0] p_sxsy_sz_q;
  logic signed [31:0] p_cx_cz_q;
  logic signed [31:0] p_cxsy_sz_q;
  logic signed [31:0] p_sx_cz_q;
  logic signed [31:0] p_sx_cy_q;
  logic signed [31:0] p_cx_cy_q;
  logic signed [31:0] p_sy_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_sxsy_cz_q <= erm_pkg::smulq(sxsy_q, cz_q);
      p_cx_sz_q   <= erm_pkg::smulq(cx_q, sz_q);
      p_cxsy_cz_q <= erm_pkg::smulq(cxsy_q, cz_q);
      p_sx_sz_q   <= erm_pkg::smulq(sx_q, sz_q);
      p_cy_cz_q   <= erm_pkg::smulq(cy_q, cz_q);
      p_cy_sz_q   <= erm_pkg::smulq(cy_q, sz_q);
      p_sxsy_sz_q <= erm_pkg::smulq(sxsy_q, sz_q);
      p_cx_cz_q   <= erm_pkg::smulq(cx_q, cz_q);
      p_cxsy_sz_q <= erm_pkg::smulq(cxsy_q, sz_q);
      p_sx_cz_q   <= erm_pkg::smulq(sx_q, cz_q);
      p_sx_cy_q   <= erm_pkg::smulq(sx_q, cy_q);
      p_cx_cy_q   <= erm_pkg::smulq(cx_q, cy_q);
      p_sy_q      <= sy_q;
    end
  end

  // Sums, rounding and saturation into the output register.
  function automatic logic signed [32:0] ext(input logic signed [31:0] a);
    return {a[31], a};
  endfunction

  always_ff @(posedge clk_i) begin
    if (en) begin
      matrix_o.m00 <= $signed(to_out(ext(p_cy_cz_q)));
      matrix_o.m01 <= $signed(to_out(ext(p_sxsy_cz_q) - ext(p_cx_sz_q)));
      matrix_o.m02 <= $signed(to_out(ext(p_cxsy_cz_q) + ext(p_sx_sz_q)));
      matrix_o.m10 <= $signed(to_out(ext(p_cy_sz_q)));
      matrix_o.m11 <= $signed(to_out(ext(p_sxsy_sz_q) + ext(p_cx_cz_q)));
      matrix_o.m12 <= $signed(to_out(ext(p_cxsy_sz_q) - ext(p_sx_cz_q)));
      matrix_o.m20 <= $signed(to_out(-ext(p_sy_q)));
      matrix_o.m21 <= $signed(to_out(ext(p_sx_cy_q)));
      matrix_o.m22 <= $signed(to_out(ext(p_cx_cy_q)));
    end
  end

endmodule

@@ bench/euler_rotation_matrix_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Euler rotation matrix testbench
// Drives angle triples through the valid/ready channel and checks all nine
// matrix entries against a bit-exact fixed-point predictor, under random
// idling on both sides, a long output hold-off and full drains.
// ----------------------------------------------------------------------------

// Expected matrix entries for one angle triple, plus the angles for reports.
typedef struct {
  logic signed [15:0] ang [3];
  logic signed [15:0] ent [9];
} matrix_exp_t;

class rotation_scoreboard;
  matrix_exp_t pending[$];
  int unsigned errors;
  int unsigned checked;

  function new();
    errors  = 0;
    checked = 0;
  endfunction

  // Q30 unsigned product with rounding half up.
  static function logic [63:0] mul_q30(logic [63:0] a, logic [63:0] b);
    return (a * b + 64'h2000_0000) >> 30;
  endfunction

  // Signed Q30 product, magnitude rounded half up.
  static function longint prod_q30(longint a, longint b);
    logic   neg;
    longint m;
    neg = (a < 0) != (b < 0);
    m   = longint'(mul_q30(a < 0 ? -a : a, b < 0 ? -b : b));
    return neg ? -m : m;
  endfunction

  // Sine and cosine of a Q30 radian value in the first octant.
  static function void octant(logic [63:0] x, output logic [63:0] s,
                              output logic [63:0] c);
    logic [63:0] x2;
    logic [63:0] ts;
    logic [63:0] tc;
    x2 = mul_q30(x, x);
    ts = 64'h4000_0000;
    tc = 64'h4000_0000;
    for (int k = 9; k >= 1; k--) begin
      ts = 64'h4000_0000 - mul_q30(x2, ts) / ((2 * k) * (2 * k + 1));
      tc = 64'h4000_0000 - mul_q30(x2, tc) / ((2 * k - 1) * (2 * k));
    end
    s = mul_q30(x, ts);
    c = tc;
  endfunction

  // Signed sine and cosine of one 16-bit angle in degrees, six fraction bits.
  static function void angle_sincos(logic signed [15:0] a, output longint sn,
                                    output longint cs);
    longint      r;
    longint      q;
    longint      t;
    logic [63:0] rad;
    logic [63:0] s;
    logic [63:0] c;
    r = longint'(a) % (360 << 6);
    if (r < 0) r += 360 << 6;
    q = r / (90 << 6);
    t = r - q * (90 << 6);
    if (t <= (45 << 6)) begin
      rad = (t * 64'd76760392275 + (64'd1 << 17)) >> 18;
      octant(rad, s, c);
    end else begin
      rad = (((90 << 6) - t) * 64'd76760392275 + (64'd1 << 17)) >> 18;
      octant(rad, c, s);
    end
    case (q)
      0: begin sn = s;  cs = c;  end
      1: begin sn = c;  cs = -s; end
      2: begin sn = -s; cs = -c; end
      default: begin sn = -c; cs = s; end
    endcase
  endfunction

  // Q30 to Q1.14, half away from zero, saturated to +-1.0.
  static function logic signed [15:0] to_q14(longint v);
    longint m;
    m = v < 0 ? -v : v;
    m = (m + (1 << 15)) >> 16;
    if (m > 16384) m = 16384;
    return 16'(v < 0 ? -m : m);
  endfunction

  function void note_angles(logic signed [15:0] ax, logic signed [15:0] ay,
                            logic signed [15:0] az);
    matrix_exp_t e;
    longint sx, cx, sy, cy, sz, cz, sxsy, cxsy;
    angle_sincos(ax, sx, cx);
    angle_sincos(ay, sy, cy);
    angle_sincos(az, sz, cz);
    sxsy = prod_q30(sx, sy);
    cxsy = prod_q30(cx, sy);
    e.ang[0] = ax; e.ang[1] = ay; e.ang[2] = az;
    e.ent[0] = to_q14(prod_q30(cy, cz));
    e.ent[1] = to_q14(prod_q30(sxsy, cz) - prod_q30(cx, sz));
    e.ent[2] = to_q14(prod_q30(cxsy, cz) + prod_q30(sx, sz));
    e.ent[3] = to_q14(prod_q30(cy, sz));
    e.ent[4] = to_q14(prod_q30(sxsy, sz) + prod_q30(cx, cz));
    e.ent[5] = to_q14(prod_q30(cxsy, sz) - prod_q30(sx, cz));
    e.ent[6] = to_q14(-sy);
    e.ent[7] = to_q14(prod_q30(sx, cy));
    e.ent[8] = to_q14(prod_q30(cx, cy));
    pending.push_back(e);
  endfunction

  task report(string msg);
    errors++;
    if (errors <= 40) $display("[%0t] error: %s", $realtime, msg);
  endtask

  task check_matrix(logic signed [15:0] got [9]);
    matrix_exp_t e;
    if (pending.size() == 0) begin
      report("matrix arrived with no angle triple outstanding");
      return;
    end
    e = pending.pop_front();
    checked++;
    for (int i = 0; i < 9; i++)
      if (got[i] !== e.ent[i])
        report($sformatf("angles (%0d,%0d,%0d) m%0d%0d got %0d want %0d",
                         e.ang[0], e.ang[1], e.ang[2], i / 3, i % 3, got[i],
                         e.ent[i]));
  endtask
endclass

module euler_rotation_matrix_test;

  localparam int PIPE_CYCLES = erm_pkg::TRIG_LAT + erm_pkg::PROD_LAT;

  logic clk_i;
  logic rst_ni;

  erm_in_if  angle_ch ();
  erm_out_if matrix_ch ();

  euler_rotation_matrix i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .angle_i  (angle_ch.sink),
    .matrix_o (matrix_ch.source)
  );

  rotation_scoreboard board;
  int  send_idle_pct;
  int  recv_idle_pct;
  int  hold_cycles;
  bit  timed_out;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Send one angle triple and wait for it to be taken.
  task send_angles(logic signed [15:0] ax, logic signed [15:0] ay,
                   logic signed [15:0] az);
    while ($urandom_range(99) < send_idle_pct) begin
      angle_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    angle_ch.valid   <= 1'b1;
    angle_ch.angle_x <= ax;
    angle_ch.angle_y <= ay;
    angle_ch.angle_z <= az;
    do @(posedge clk_i); while (!angle_ch.ready);
    board.note_angles(ax, ay, az);
  endtask

  task go_quiet();
    angle_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Random angle: mostly uniform, sometimes near multiples of 45 degrees.
  function logic signed [15:0] pick_angle();
    int m;
    if ($urandom_range(3) == 0) begin
      m = ($urandom_range(10) - 5) * (45 << 6) + $urandom_range(4) - 2;
      return 16'(m);
    end
    return 16'($urandom);
  endfunction

  task random_phase(int n);
    for (int i = 0; i < n; i++) send_angles(pick_angle(), pick_angle(), pick_angle());
  endtask

  task drain();
    go_quiet();
    while (board.pending.size() != 0) @(posedge clk_i);
  endtask

  // Receiver: random stalls, or a long counted hold-off when requested.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      matrix_ch.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      matrix_ch.ready <= 1'b0;
    end else begin
      matrix_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Check every matrix taken at a clock edge.
  always @(posedge clk_i) begin
    if (rst_ni && matrix_ch.valid && matrix_ch.ready)
      board.check_matrix('{matrix_ch.m00, matrix_ch.m01, matrix_ch.m02,
                           matrix_ch.m10, matrix_ch.m11, matrix_ch.m12,
                           matrix_ch.m20, matrix_ch.m21, matrix_ch.m22});
  end

  initial begin
    #20ms;
    $display("run timed out");
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    logic signed [15:0] edges [12];
    board = new();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_cycles   = 0;
    rst_ni = 1'b0;
    angle_ch.valid   <= 1'b0;
    angle_ch.angle_x <= '0;
    angle_ch.angle_y <= '0;
    angle_ch.angle_z <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: field extremes, full turns, quadrant and octant borders.
    edges = '{16'sh7FFF, -16'sh8000, 0, -1, 1, 45 << 6, (45 << 6) + 1,
              90 << 6, 180 << 6, -(90 << 6), 360 << 6, (270 << 6) - 1};
    for (int i = 0; i < 12; i++)
      send_angles(edges[i], edges[(i + 3) % 12], edges[(i + 7) % 12]);
    send_angles(16'sh5555, 16'shAAAA, 16'sh0F0F);
    send_angles(16'shAAAA, 16'sh5555, 16'shF0F0);
    drain();

    // Long output hold-off while the input keeps offering triples.
    hold_cycles = 150;
    random_phase(80);
    drain();

    send_idle_pct = 23; recv_idle_pct = 87;
    random_phase(450);
    drain();
    send_idle_pct = 87; recv_idle_pct = 23;
    random_phase(450);
    drain();
    send_idle_pct = 0; recv_idle_pct = 0;
    random_phase(450);
    drain();
    repeat (PIPE_CYCLES + 10) @(posedge clk_i);

    $display("Checked %0d matrices from directed and random angle triples,",
             board.checked);
    $display("under mixed stalls, a long output hold-off and full drains.");
    if (board.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", board.errors);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

@@ euler_rotation_matrix.f @@
rtl/erm_pkg.sv
rtl/erm_if.sv
rtl/erm_trig.sv
rtl/euler_rotation_matrix.sv
bench/euler_rotation_matrix_test.sv
